@@ rtl/dual_arm_hold_stability_monitor_unit_macros.svh @@
// assertion macros for the dual-arm hold stability monitor checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef DUAL_ARM_HOLD_STABILITY_MONITOR_UNIT_MACROS_SVH
`define DUAL_ARM_HOLD_STABILITY_MONITOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DAHSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DAHSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dahsm_pkg.sv @@
// shared types, constants and helper functions of the hold stability monitor
// no dependencies
`default_nettype none

package dahsm_pkg;

  localparam int NumJoints     = 6;
  localparam int JointW        = 3;
  localparam int PosW          = 12;
  localparam int PosModulus    = 1 << PosW;
  localparam int HalfTurn      = PosModulus / 2;
  localparam int StampW        = 32;
  localparam int TolW          = 11;
  localparam int MsW           = 31;
  localparam int TgtW          = 48;
  localparam int TgtPairW      = 2 * PosW;
  localparam int NumTargetRegs = 3;
  localparam int CfgIdxW       = 3;
  localparam int TreeLeaves    = 1 << $clog2(NumJoints);

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_AFTER_STAMP = 3'd0,
    CFG_TOLERANCE   = 3'd1,
    CFG_DWELL_TIME  = 3'd2,
    CFG_MAX_AGE     = 3'd3,
    CFG_TARGETS_01  = 3'd4,
    CFG_TARGETS_23  = 3'd5,
    CFG_TARGETS_45  = 3'd6
  } cfg_reg_e;

  // item kinds
  typedef enum logic {
    KIND_OBSERVE = 1'b0,
    KIND_CHECK   = 1'b1
  } kind_e;

  typedef struct packed {
    logic              kind;
    logic [JointW-1:0] joint;
    logic [PosW-1:0]   left_pos;
    logic [PosW-1:0]   right_pos;
    logic [StampW-1:0] sample_stamp;
    logic [StampW-1:0] now;
  } obs_item_t;

  typedef struct packed {
    logic              accepted;
    logic              held;
    logic [StampW-1:0] oldest_stamp;
  } hold_result_t;

  typedef struct packed {
    logic [StampW-1:0]                   after_stamp;
    logic [TolW-1:0]                     tolerance;
    logic [MsW-1:0]                      dwell_time;
    logic [MsW-1:0]                      max_age;
    logic [NumTargetRegs-1:0][TgtW-1:0]  targets;
  } cfg_t;

  typedef struct packed {
    logic [NumJoints-1:0]             seen;
    logic [NumJoints-1:0]             stable;
    logic [NumJoints-1:0][StampW-1:0] last_stamp;
    logic [NumJoints-1:0][StampW-1:0] stable_start;
  } joint_state_t;

  // serial-number compare: a strictly newer than b
  function automatic logic is_newer(logic [StampW-1:0] a, logic [StampW-1:0] b);
    logic [StampW-1:0] d;
    d = a - b;
    return (d != '0) && !d[StampW-1];
  endfunction

  // distance between two encoder readings on the wrapped circle
  function automatic logic [PosW-1:0] wrap_dist(logic [PosW-1:0] a, logic [PosW-1:0] b);
    logic [PosW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return ({1'b0, d} > (PosW+1)'(HalfTurn)) ? (PosW'(0) - d) : d;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dahsm_cfg_regs.sv @@
// configuration registers of the hold stability monitor
// depends on dahsm_pkg
`default_nettype none

module dahsm_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            busy_i,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [dahsm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [dahsm_pkg::TgtW-1:0]      cfg_data_i,
  output dahsm_pkg::cfg_t                      cfg_o,
  output logic                                 clear_o
);

  dahsm_pkg::cfg_t cfg_q, cfg_d;
  logic            wr;
  logic            known;

  // writes are taken only while busy_i is low
  assign cfg_ready_o = !busy_i;
  assign wr          = cfg_valid_i && cfg_ready_o;

  // decode the register index
  always_comb begin
    cfg_d = cfg_q;
    known = 1'b1;
    unique case (dahsm_pkg::cfg_reg_e'(cfg_index_i))
      dahsm_pkg::CFG_AFTER_STAMP: cfg_d.after_stamp = cfg_data_i[dahsm_pkg::StampW-1:0];
      dahsm_pkg::CFG_TOLERANCE:   cfg_d.tolerance   = cfg_data_i[dahsm_pkg::TolW-1:0];
      dahsm_pkg::CFG_DWELL_TIME:  cfg_d.dwell_time  = cfg_data_i[dahsm_pkg::MsW-1:0];
      dahsm_pkg::CFG_MAX_AGE:     cfg_d.max_age     = cfg_data_i[dahsm_pkg::MsW-1:0];
      dahsm_pkg::CFG_TARGETS_01:  cfg_d.targets[0]  = cfg_data_i;
      dahsm_pkg::CFG_TARGETS_23:  cfg_d.targets[1]  = cfg_data_i;
      dahsm_pkg::CFG_TARGETS_45:  cfg_d.targets[2]  = cfg_data_i;
      default:                    known             = 1'b0;
    endcase
  end

  // a write to a known register also clears the joint state
  assign clear_o = wr && known;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.after_stamp <= '0;
      cfg_q.tolerance   <= dahsm_pkg::TolW'(16);
      cfg_q.dwell_time  <= dahsm_pkg::MsW'(1);
      cfg_q.max_age     <= dahsm_pkg::MsW'(1);
      cfg_q.targets     <= '0;
    end else if (wr) begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/dahsm_joint_state.sv @@
// per-joint sample checks and state registers of the hold stability monitor
// depends on dahsm_pkg
`default_nettype none

module dahsm_joint_state (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  upd_en_i,
  input  wire dahsm_pkg::obs_item_t  item_i,
  input  wire logic                  clear_i,
  input  wire dahsm_pkg::cfg_t       cfg_i,
  output dahsm_pkg::joint_state_t    state_o,
  output logic                       accepted_o
);

  dahsm_pkg::joint_state_t st_q, st_d;

  logic                           joint_ok;
  logic                           sel_seen;
  logic                           sel_stable;
  logic [dahsm_pkg::StampW-1:0]   sel_last;
  logic [dahsm_pkg::PosW-1:0]     tgt_l;
  logic [dahsm_pkg::PosW-1:0]     tgt_r;
  logic [dahsm_pkg::StampW-1:0]   age_now;
  logic [dahsm_pkg::StampW-1:0]   gap;
  logic                           reject;
  logic                           continuous;
  logic                           in_tol;
  logic                           is_obs;

  assign joint_ok = item_i.joint < dahsm_pkg::JointW'(dahsm_pkg::NumJoints);
  assign is_obs   = item_i.kind == dahsm_pkg::KIND_OBSERVE;

  // select the addressed joint's state and targets
  always_comb begin
    sel_seen   = 1'b0;
    sel_stable = 1'b0;
    sel_last   = '0;
    tgt_l      = '0;
    tgt_r      = '0;
    for (int j = 0; j < dahsm_pkg::NumJoints; j++) begin
      if (item_i.joint == dahsm_pkg::JointW'(j)) begin
        sel_seen   = st_q.seen[j];
        sel_stable = st_q.stable[j];
        sel_last   = st_q.last_stamp[j];
        if ((j >> 1) < dahsm_pkg::NumTargetRegs) begin
          tgt_l = cfg_i.targets[j >> 1][(j & 1) * dahsm_pkg::TgtPairW +: dahsm_pkg::PosW];
          tgt_r = cfg_i.targets[j >> 1][(j & 1) * dahsm_pkg::TgtPairW + dahsm_pkg::PosW
                                        +: dahsm_pkg::PosW];
        end
      end
    end
  end

  // staleness, ordering, continuity and tolerance checks
  always_comb begin
    age_now    = item_i.now - item_i.sample_stamp;
    gap        = item_i.sample_stamp - sel_last;
    reject     = (age_now >= {1'b0, cfg_i.max_age})
              || !dahsm_pkg::is_newer(item_i.sample_stamp, cfg_i.after_stamp)
              || (sel_seen && !dahsm_pkg::is_newer(item_i.sample_stamp, sel_last));
    continuous = sel_seen && (gap < {1'b0, cfg_i.max_age});
    in_tol     = (dahsm_pkg::wrap_dist(item_i.left_pos, tgt_l)  <= {1'b0, cfg_i.tolerance})
              && (dahsm_pkg::wrap_dist(item_i.right_pos, tgt_r) <= {1'b0, cfg_i.tolerance});
  end

  assign accepted_o = is_obs && joint_ok && !reject && in_tol;

  // next state of the addressed joint, or of all joints on a clear
  always_comb begin
    st_d = st_q;
    if (clear_i) begin
      st_d = '0;
    end else if (upd_en_i && is_obs && joint_ok) begin
      for (int j = 0; j < dahsm_pkg::NumJoints; j++) begin
        if (item_i.joint == dahsm_pkg::JointW'(j)) begin
          if (reject) begin
            st_d.stable[j] = 1'b0;
          end else begin
            st_d.seen[j]       = 1'b1;
            st_d.last_stamp[j] = item_i.sample_stamp;
            if (!in_tol) begin
              st_d.stable[j] = 1'b0;
            end else if (!continuous || !sel_stable) begin
              st_d.stable_start[j] = item_i.sample_stamp;
              st_d.stable[j]       = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign state_o = st_q;

endmodule

`default_nettype wire

@@ rtl/dahsm_hold_check.sv @@
// all-joint hold check: per-joint age and dwell compares, then a max-age tree
// depends on dahsm_pkg
`default_nettype none

module dahsm_hold_check (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         adv_i,
  input  wire dahsm_pkg::joint_state_t      state_i,
  input  wire dahsm_pkg::cfg_t              cfg_i,
  input  wire logic [dahsm_pkg::StampW-1:0] now_i,
  output logic                              held_o,
  output logic [dahsm_pkg::StampW-1:0]      oldest_o
);

  logic [dahsm_pkg::NumJoints-1:0][dahsm_pkg::StampW-1:0] age;
  logic [dahsm_pkg::NumJoints-1:0][dahsm_pkg::StampW-1:0] age_q;
  logic [dahsm_pkg::NumJoints-1:0]                        fresh;
  logic [dahsm_pkg::NumJoints-1:0]                        dwell_ok;
  logic [dahsm_pkg::StampW-1:0]                           run;
  logic [dahsm_pkg::StampW-1:0]                           now_q;
  logic                                                   ok, ok_q;
  logic [dahsm_pkg::StampW-1:0]                           node [2*dahsm_pkg::TreeLeaves];

  // per-joint freshness and dwell compares, all in parallel
  always_comb begin
    for (int j = 0; j < dahsm_pkg::NumJoints; j++) begin
      age[j]      = now_i - state_i.last_stamp[j];
      fresh[j]    = age[j] < {1'b0, cfg_i.max_age};
      run         = state_i.last_stamp[j] - state_i.stable_start[j];
      dwell_ok[j] = run >= {1'b0, cfg_i.dwell_time};
    end
    ok = (&state_i.seen) && (&state_i.stable) && (&fresh) && (&dwell_ok);
  end

  // stage register between the compares and the tree
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else if (adv_i) begin
      ok_q <= ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      age_q <= age;
      now_q <= now_i;
    end
  end

  // binary max tree over the ages, root at node 1
  always_comb begin
    for (int i = 0; i < 2 * dahsm_pkg::TreeLeaves; i++) begin
      node[i] = '0;
    end
    for (int i = 0; i < dahsm_pkg::NumJoints; i++) begin
      node[dahsm_pkg::TreeLeaves + i] = age_q[i];
    end
    for (int i = dahsm_pkg::TreeLeaves - 1; i >= 1; i--) begin
      node[i] = (node[2*i] > node[2*i+1]) ? node[2*i] : node[2*i+1];
    end
  end

  assign held_o   = ok_q;
  assign oldest_o = ok_q ? (now_q - node[1]) : '0;

endmodule

`default_nettype wire

@@ rtl/dual_arm_hold_stability_monitor_unit.sv @@
// Dual-arm hold stability monitor, top level.
// Depends on dahsm_pkg, dahsm_cfg_regs, dahsm_joint_state, dahsm_hold_check.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): one request per item,
// either an observe of one joint's left and right encoder reading with its
// sample stamp and current time, or a plain hold check.
// Output channel (out_valid_o / out_stall_i / out_item_o): one result per
// request: accepted flag, held flag and the oldest sample stamp.
// Config channel (cfg_valid_i / cfg_ready_o): register index and data; a
// write to a known register clears all joint state. Ready is low while a
// request is in the first two pipeline stages.
// Throughput: one request per cycle while the output is not stalled; the
// joint state is read and written in the same stage, so a request sees
// everything its predecessor left.
// Reset clears the state and the pipeline and loads the register defaults.
// A stall on a valid output result holds the whole pipeline and raises in_stall_o in
// the same cycle; a held result stays unchanged until taken.
`default_nettype none

module dual_arm_hold_stability_monitor_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire dahsm_pkg::obs_item_t          in_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output dahsm_pkg::hold_result_t            out_item_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [dahsm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [dahsm_pkg::TgtW-1:0]    cfg_data_i
);

  logic                         adv;
  logic                         s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  dahsm_pkg::obs_item_t         s1_item_q;
  logic [dahsm_pkg::StampW-1:0] s2_now_q;
  logic                         s2_acc_q, s3_acc_q;
  logic                         acc;
  logic                         clear;
  logic                         held;
  logic [dahsm_pkg::StampW-1:0] oldest;
  dahsm_pkg::cfg_t              cfg;
  dahsm_pkg::joint_state_t      state;
  dahsm_pkg::hold_result_t      out_q;

  // whole pipeline moves unless a finished result is stalled
  assign adv         = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  dahsm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .busy_i      (s1_valid_q || s2_valid_q),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .clear_o     (clear)
  );

  dahsm_joint_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_en_i   (adv && s1_valid_q),
    .item_i     (s1_item_q),
    .clear_i    (clear),
    .cfg_i      (cfg),
    .state_o    (state),
    .accepted_o (acc)
  );

  dahsm_hold_check u_hold (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .state_i  (state),
    .cfg_i    (cfg),
    .now_i    (s2_now_q),
    .held_o   (held),
    .oldest_o (oldest)
  );

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  // stage payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_item_q            <= in_item_i;
      s2_now_q             <= s1_item_q.now;
      s2_acc_q             <= acc && s1_valid_q;
      s3_acc_q             <= s2_acc_q;
      out_q.accepted       <= s3_acc_q;
      out_q.held           <= held;
      out_q.oldest_stamp   <= oldest;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dahsm_checker.sv @@
// port-level checker for the hold stability monitor, bound to the top level
// depends on dahsm_pkg and dual_arm_hold_stability_monitor_unit_macros.svh
`default_nettype none

`include "dual_arm_hold_stability_monitor_unit_macros.svh"

module dahsm_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire dahsm_pkg::obs_item_t          in_item_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire dahsm_pkg::hold_result_t       out_item_o,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_o,
  input wire logic [dahsm_pkg::CfgIdxW-1:0] cfg_index_i,
  input wire logic [dahsm_pkg::TgtW-1:0]    cfg_data_i
);

  // a stalled result stays offered
  `DAHSM_ASSERT_NEXT(a_out_valid_holds, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // a stalled result keeps its payload
  `DAHSM_ASSERT_NEXT(a_out_item_holds, out_valid_o && out_stall_i, $stable(out_item_o), "result changed while stalled")

  // input backpressure only when a finished result is stalled
  `DAHSM_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled without output stall")

  // the oldest stamp reads zero unless the arms are held
  `DAHSM_ASSERT_NOW(a_oldest_zero, out_valid_o && !out_item_o.held, out_item_o.oldest_stamp == '0, "oldest stamp set without hold")

endmodule

bind dual_arm_hold_stability_monitor_unit dahsm_checker u_dahsm_checker (.*);

`default_nettype wire
